[rtl/core/tsm_pkg.sv]
// Shared types, constants and codes for the touch to screen mapper.
`timescale 1ns / 1ps
`default_nettype none

package tsm_pkg;

  localparam int COORD_W = 16;
  localparam int SCR_W   = 14;
  localparam int TIME_W  = 32;
  localparam int PROD_W  = COORD_W + SCR_W;
  localparam int CNT_W   = $clog2(PROD_W);

  localparam logic [COORD_W-1:0] PAD_RANGE_X  = 16'd4095;
  localparam logic [COORD_W-1:0] PAD_RANGE_Y  = 16'd4095;
  localparam logic [TIME_W-1:0]  TAP_LIMIT_MS = 32'd200;

  // Input event modes.
  localparam logic [1:0] MODE_X    = 2'd0;
  localparam logic [1:0] MODE_Y    = 2'd1;
  localparam logic [1:0] MODE_AXIS = 2'd2;
  localparam logic [1:0] MODE_KEY  = 2'd3;

  localparam logic [COORD_W-1:0] KEY_RELEASE = 16'd0;
  localparam logic [COORD_W-1:0] KEY_PRESS   = 16'd1;

  // Result kinds.
  localparam logic [1:0] KIND_X    = 2'd0;
  localparam logic [1:0] KIND_Y    = 2'd1;
  localparam logic [1:0] KIND_SYNC = 2'd2;
  localparam logic [1:0] KIND_BTN  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLED     = 3'd0;
  localparam logic [2:0] REG_AREA_ENABLE = 3'd1;
  localparam logic [2:0] REG_AREA_LEFT   = 3'd2;
  localparam logic [2:0] REG_AREA_TOP    = 3'd3;
  localparam logic [2:0] REG_AREA_RIGHT  = 3'd4;
  localparam logic [2:0] REG_AREA_BOTTOM = 3'd5;
  localparam logic [2:0] REG_SCREEN_W    = 3'd6;
  localparam logic [2:0] REG_SCREEN_H    = 3'd7;

  // Commands passed from the front to the back.
  localparam logic [1:0] OP_MAP_X = 2'd0;
  localparam logic [1:0] OP_MAP_Y = 2'd1;
  localparam logic [1:0] OP_SYNC  = 2'd2;
  localparam logic [1:0] OP_TAP   = 2'd3;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [1:0]         mode;
    logic [COORD_W-1:0] value;
    logic [TIME_W-1:0]  time_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SCR_W-1:0] out_value;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic               enabled;
    logic               area_enable;
    logic [COORD_W-1:0] area_left;
    logic [COORD_W-1:0] area_top;
    logic [COORD_W-1:0] area_right;
    logic [COORD_W-1:0] area_bottom;
    logic [SCR_W-1:0]   screen_w;
    logic [SCR_W-1:0]   screen_h;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

[rtl/core/tsm_cmd_fifo.sv]
// Short command queue between the event front and the mapping back.
`timescale 1ns / 1ps
`default_nettype none

module tsm_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tsm_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output tsm_pkg::cmd_t     head_cmd,
  output tsm_pkg::fifo_stat_t stat
);

  tsm_pkg::cmd_t                mem_r [tsm_pkg::FIFO_DEPTH];
  logic [tsm_pkg::FIFO_AW-1:0]  wr_ptr_r;
  logic [tsm_pkg::FIFO_AW-1:0]  rd_ptr_r;
  logic [tsm_pkg::FIFO_AW:0]    count_r;
  logic                         do_push;
  logic                         do_pop;

  assign stat.full  = (count_r == (tsm_pkg::FIFO_AW+1)'(tsm_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      priority if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end else begin
        count_r <= count_r;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/tsm_front.sv]
// Event front: accepts input words, keeps tap state and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module tsm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsm_pkg::in_word_t   in_word,
  input  logic                enabled,
  input  tsm_pkg::fifo_stat_t stat,
  output logic                push,
  output tsm_pkg::cmd_t       push_cmd
);

  logic                        tap_pending_r;
  logic                        tap_pending_nxt;
  logic [tsm_pkg::TIME_W-1:0]  press_time_r;
  logic [tsm_pkg::TIME_W-1:0]  press_time_nxt;
  logic [tsm_pkg::TIME_W-1:0]  elapsed;
  logic                        accept;
  logic                        quick_tap;

  assign in_ready  = !stat.full;
  assign accept    = in_valid && in_ready;
  // Elapsed time wraps modulo 2^32, so a plain subtract is correct.
  assign elapsed   = in_word.time_ms - press_time_r;
  assign quick_tap = (elapsed < tsm_pkg::TAP_LIMIT_MS);

  always_comb begin
    push            = 1'b0;
    push_cmd.op     = tsm_pkg::OP_SYNC;
    push_cmd.value  = in_word.value;
    tap_pending_nxt = tap_pending_r;
    press_time_nxt  = press_time_r;
    if (accept && enabled) begin
      unique case (in_word.mode)
        tsm_pkg::MODE_X: begin
          push        = 1'b1;
          push_cmd.op = tsm_pkg::OP_MAP_X;
        end
        tsm_pkg::MODE_Y: begin
          push        = 1'b1;
          push_cmd.op = tsm_pkg::OP_MAP_Y;
        end
        tsm_pkg::MODE_AXIS: begin
          push        = 1'b1;
          push_cmd.op = tsm_pkg::OP_SYNC;
        end
        tsm_pkg::MODE_KEY: begin
          priority if (in_word.value == tsm_pkg::KEY_PRESS) begin
            press_time_nxt  = in_word.time_ms;
            tap_pending_nxt = 1'b1;
          end else if (in_word.value == tsm_pkg::KEY_RELEASE && tap_pending_r) begin
            push            = quick_tap;
            push_cmd.op     = tsm_pkg::OP_TAP;
            tap_pending_nxt = 1'b0;
          end else begin
            // Repeats and stray releases leave the tap state alone.
            tap_pending_nxt = tap_pending_r;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_pending_r <= 1'b0;
      press_time_r  <= '0;
    end else begin
      tap_pending_r <= tap_pending_nxt;
      press_time_r  <= press_time_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tsm_back.sv]
// Mapping back: scales coordinates with a serial divider and emits result words.
`timescale 1ns / 1ps
`default_nettype none

module tsm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tsm_pkg::cfg_t       cfg,
  input  tsm_pkg::fifo_stat_t stat,
  input  tsm_pkg::cmd_t       head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output tsm_pkg::out_word_t  out_word
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]                   state_r;
  tsm_pkg::cmd_t                cmd_r;
  logic [tsm_pkg::COORD_W-1:0]  diff_r;
  logic [tsm_pkg::COORD_W-1:0]  den_r;
  logic                         zero_r;
  logic [tsm_pkg::PROD_W-1:0]   num_r;
  logic [tsm_pkg::COORD_W-1:0]  rem_r;
  logic [tsm_pkg::CNT_W-1:0]    cnt_r;
  logic [tsm_pkg::SCR_W-1:0]    q_r;
  logic [1:0]                   seq_r;
  logic                         out_valid_r;
  tsm_pkg::out_word_t           out_word_r;

  logic                         is_x;
  logic [tsm_pkg::COORD_W-1:0]  lo;
  logic [tsm_pkg::COORD_W-1:0]  hi;
  logic [tsm_pkg::COORD_W-1:0]  range;
  logic [tsm_pkg::SCR_W-1:0]    scr;
  logic [tsm_pkg::COORD_W-1:0]  clamped;
  logic [tsm_pkg::COORD_W:0]    rem_sh;
  logic                         rem_ge;
  logic                         can_load;
  tsm_pkg::out_word_t           emit_word;

  assign is_x  = (cmd_r.op == tsm_pkg::OP_MAP_X);
  assign lo    = is_x ? cfg.area_left  : cfg.area_top;
  assign hi    = is_x ? cfg.area_right : cfg.area_bottom;
  assign range = is_x ? tsm_pkg::PAD_RANGE_X : tsm_pkg::PAD_RANGE_Y;
  assign scr   = is_x ? cfg.screen_w : cfg.screen_h;

  always_comb begin
    clamped = cmd_r.value;
    priority if (cmd_r.value < lo) begin
      clamped = lo;
    end else if (cmd_r.value > hi) begin
      clamped = hi;
    end else begin
      clamped = cmd_r.value;
    end
  end

  // One restoring step per cycle, one quotient bit per step.
  assign rem_sh = {rem_r, num_r[tsm_pkg::PROD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_r});

  assign can_load  = !out_valid_r || out_ready;
  assign pop       = (state_r == ST_IDLE) && !stat.empty;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    emit_word.kind      = tsm_pkg::KIND_SYNC;
    emit_word.out_value = '0;
    emit_word.last      = 1'b1;
    unique case (cmd_r.op)
      tsm_pkg::OP_MAP_X, tsm_pkg::OP_MAP_Y: begin
        if (seq_r == 2'd0) begin
          emit_word.kind      = is_x ? tsm_pkg::KIND_X : tsm_pkg::KIND_Y;
          emit_word.out_value = q_r;
          emit_word.last      = 1'b0;
        end
      end
      tsm_pkg::OP_TAP: begin
        unique case (seq_r)
          2'd0: begin
            emit_word.kind      = tsm_pkg::KIND_BTN;
            emit_word.out_value = tsm_pkg::SCR_W'(1);
            emit_word.last      = 1'b0;
          end
          2'd1: begin
            emit_word.last = 1'b0;
          end
          2'd2: begin
            emit_word.kind = tsm_pkg::KIND_BTN;
            emit_word.last = 1'b0;
          end
          default: begin
            emit_word.last = 1'b1;
          end
        endcase
      end
      default: begin
        emit_word.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_EMIT && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!stat.empty) begin
            if (head_cmd.op == tsm_pkg::OP_MAP_X || head_cmd.op == tsm_pkg::OP_MAP_Y) begin
              state_r <= ST_PREP;
            end else begin
              state_r <= ST_EMIT;
            end
          end
        end
        ST_PREP: begin
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= zero_r ? ST_EMIT : ST_DIV;
        end
        ST_DIV: begin
          if (cnt_r == tsm_pkg::CNT_W'(tsm_pkg::PROD_W - 1)) begin
            state_r <= ST_SAT;
          end
        end
        ST_SAT: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (can_load && emit_word.last) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        cmd_r <= head_cmd;
        seq_r <= 2'd0;
      end
      ST_PREP: begin
        if (cfg.area_enable) begin
          zero_r <= (hi <= lo);
          diff_r <= clamped - lo;
          den_r  <= hi - lo;
        end else begin
          zero_r <= 1'b0;
          diff_r <= cmd_r.value;
          den_r  <= range;
        end
      end
      ST_MUL: begin
        num_r <= {{(tsm_pkg::PROD_W-tsm_pkg::COORD_W){1'b0}}, diff_r} *
                 {{(tsm_pkg::PROD_W-tsm_pkg::SCR_W){1'b0}}, scr};
        rem_r <= '0;
        cnt_r <= '0;
        q_r   <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_ge ? tsm_pkg::COORD_W'(rem_sh - {1'b0, den_r})
                        : rem_sh[tsm_pkg::COORD_W-1:0];
        num_r <= {num_r[tsm_pkg::PROD_W-2:0], rem_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_SAT: begin
        if (num_r > {{(tsm_pkg::PROD_W-tsm_pkg::SCR_W){1'b0}}, scr}) begin
          q_r <= scr;
        end else begin
          q_r <= num_r[tsm_pkg::SCR_W-1:0];
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_word_r <= emit_word;
          seq_r      <= seq_r + 1'b1;
        end
      end
      default: begin
        seq_r <= 2'd0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && !zero_r) |=> (state_r == ST_DIV))
    else $error("divider did not start after the multiply");

  a_last_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.last) |-> (out_word_r.kind == tsm_pkg::KIND_SYNC))
    else $error("final word of an event is not a sync");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < tsm_pkg::CNT_W'(tsm_pkg::PROD_W)))
    else $error("divider step count overran the dividend width");
`endif

endmodule

`default_nettype wire

[rtl/core/touch_to_screen_mapper.sv]
// Top level of the touch to screen mapper: configuration registers and wiring.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Ports                           | Word
// input   | in_valid, in_ready, in_word     | mode, value, time_ms
// result  | out_valid, out_ready, out_word  | kind, out_value, last
// config  | cfg_valid, cfg_ready, cfg_index | cfg_data written to register cfg_index
//
// A mapped X or Y event is dequeued, clamped, multiplied, divided in the
// one-bit-per-step restoring divider, saturated, and then emitted one result
// word at a time; an empty area skips the divider and the saturate step.
// Sync-only and tap events skip the divider and go from the dequeue to their words.
// Reset is synchronous and active low; it restores the register defaults and
// clears the tap state and the command queue.
// The front keeps taking input words while the back is busy until the
// two-entry command queue fills; a stalled result channel holds the back only.

module touch_to_screen_mapper (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsm_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output tsm_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  tsm_pkg::cfg_t       cfg_r;
  tsm_pkg::fifo_stat_t stat;
  tsm_pkg::cmd_t       push_cmd;
  tsm_pkg::cmd_t       head_cmd;
  logic                push;
  logic                pop;

  // Register writes are always taken. Software is to reconfigure the block only while
  // it is idle; the block itself does not enforce this and provides no hold-off.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled     <= 1'b1;
      cfg_r.area_enable <= 1'b0;
      cfg_r.area_left   <= '0;
      cfg_r.area_top    <= '0;
      cfg_r.area_right  <= 16'd4095;
      cfg_r.area_bottom <= 16'd4095;
      cfg_r.screen_w    <= 14'd1920;
      cfg_r.screen_h    <= 14'd1080;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tsm_pkg::REG_ENABLED:     cfg_r.enabled     <= cfg_data[0];
        tsm_pkg::REG_AREA_ENABLE: cfg_r.area_enable <= cfg_data[0];
        tsm_pkg::REG_AREA_LEFT:   cfg_r.area_left   <= cfg_data;
        tsm_pkg::REG_AREA_TOP:    cfg_r.area_top    <= cfg_data;
        tsm_pkg::REG_AREA_RIGHT:  cfg_r.area_right  <= cfg_data;
        tsm_pkg::REG_AREA_BOTTOM: cfg_r.area_bottom <= cfg_data;
        tsm_pkg::REG_SCREEN_W:    cfg_r.screen_w    <= cfg_data[tsm_pkg::SCR_W-1:0];
        tsm_pkg::REG_SCREEN_H:    cfg_r.screen_h    <= cfg_data[tsm_pkg::SCR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front classifies each word and handles the tap timing itself.
  tsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .enabled  (cfg_r.enabled),
    .stat     (stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tsm_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (stat)
  );

  // The back does the clamp, scale and divide, and drives the output register.
  tsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .stat      (stat),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the touch to screen mapper, with a built-in predictor.
`timescale 1ns / 1ps

module testbench;

  // This quiet time covers a mapped coordinate's pass through the divider and
  // any word still in flight that produces no result.
  localparam int QUIET_CYCLES  = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_EVENTS = 460;
  localparam int RANDOM_PHASES = 6;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  tsm_pkg::in_word_t   in_word;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tsm_pkg::out_word_t  out_word;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [15:0]         cfg_data;

  touch_to_screen_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the register file and of the tracked touch state. These
  // mirror what the block should hold after every accepted word.
  tsm_pkg::cfg_t                       regs;
  logic [tsm_pkg::COORD_W-1:0]         pad_x;
  logic [tsm_pkg::COORD_W-1:0]         pad_y;
  logic                                press_held;
  logic [tsm_pkg::TIME_W-1:0]          press_stamp;

  // Result words still owed by the block, oldest first.
  tsm_pkg::out_word_t owed_words[$];

  int          error_count = 0;
  int          events_sent;
  int          cycle_count = 0;
  bit          idle_on;
  int          stall_run = 0;
  int          ready_roll;
  logic [31:0] now_ms;

  // Maps one raw pad coordinate to screen units. With the area enabled the
  // point is clamped into the area and the area stretched over the screen;
  // an empty area maps to zero. Either way the result saturates at the
  // screen size.
  function automatic logic [tsm_pkg::SCR_W-1:0] map_to_screen(
    input logic [tsm_pkg::COORD_W-1:0] raw,
    input logic [tsm_pkg::COORD_W-1:0] lo,
    input logic [tsm_pkg::COORD_W-1:0] hi,
    input logic [tsm_pkg::COORD_W-1:0] span,
    input logic [tsm_pkg::SCR_W-1:0]   scr
  );
    longint unsigned clamped;
    longint unsigned num;
    longint unsigned den;
    longint unsigned quot;
    if (regs.area_enable) begin
      if (hi <= lo) return '0;
      clamped = 64'(raw);
      if (clamped < 64'(lo)) clamped = 64'(lo);
      if (clamped > 64'(hi)) clamped = 64'(hi);
      num = (clamped - 64'(lo)) * 64'(scr);
      den = 64'(hi) - 64'(lo);
    end else begin
      if (span == '0) return '0;
      num = 64'(raw) * 64'(scr);
      den = 64'(span);
    end
    quot = num / den;
    if (quot > 64'(scr)) quot = 64'(scr);
    return quot[tsm_pkg::SCR_W-1:0];
  endfunction

  function automatic void owe_word(input logic [1:0] kind,
                                   input logic [tsm_pkg::SCR_W-1:0] val,
                                   input logic last);
    tsm_pkg::out_word_t w;
    w.kind      = kind;
    w.out_value = val;
    w.last      = last;
    owed_words.push_back(w);
  endfunction

  // Works out the result words of one accepted event and advances the
  // shadow touch state.
  function automatic void predict_event(input tsm_pkg::in_word_t ev);
    logic [tsm_pkg::TIME_W-1:0] elapsed;
    if (!regs.enabled) return;
    if (ev.mode == tsm_pkg::MODE_KEY) begin
      if (ev.value == tsm_pkg::KEY_PRESS) begin
        press_stamp = ev.time_ms;
        press_held  = 1'b1;
      end else if (ev.value == tsm_pkg::KEY_RELEASE && press_held) begin
        // The elapsed time wraps modulo 2^32 and is compared unsigned.
        elapsed = ev.time_ms - press_stamp;
        if (elapsed < tsm_pkg::TAP_LIMIT_MS) begin
          owe_word(tsm_pkg::KIND_BTN, tsm_pkg::SCR_W'(1), 1'b0);
          owe_word(tsm_pkg::KIND_SYNC, '0, 1'b0);
          owe_word(tsm_pkg::KIND_BTN, '0, 1'b0);
          owe_word(tsm_pkg::KIND_SYNC, '0, 1'b1);
        end
        press_held = 1'b0;
      end
      return;
    end
    if (ev.mode == tsm_pkg::MODE_X) begin
      pad_x = ev.value;
      owe_word(tsm_pkg::KIND_X,
               map_to_screen(pad_x, regs.area_left, regs.area_right,
                             tsm_pkg::PAD_RANGE_X, regs.screen_w), 1'b0);
    end else if (ev.mode == tsm_pkg::MODE_Y) begin
      pad_y = ev.value;
      owe_word(tsm_pkg::KIND_Y,
               map_to_screen(pad_y, regs.area_top, regs.area_bottom,
                             tsm_pkg::PAD_RANGE_Y, regs.screen_h), 1'b0);
    end
    // Every absolute event, the other axis included, ends with a sync.
    owe_word(tsm_pkg::KIND_SYNC, '0, 1'b1);
  endfunction

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = int'($urandom_range(0, 99));
    if (roll < 60) return 0;
    if (roll < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // Presents one event word and waits for the block to take it. Valid is
  // left high on return so that a back-to-back word needs no second
  // assignment in the same time step; any pause lowers it first.
  task automatic send_event(input logic [1:0] mode, input logic [15:0] value,
                            input logic [31:0] stamp);
    int gap;
    tsm_pkg::in_word_t ev;
    gap = pick_gap();
    ev.mode    = mode;
    ev.value   = value;
    ev.time_ms = stamp;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_event(ev);
    events_sent++;
  endtask

  // Holds off the sender until every owed word has come back.
  task automatic wait_results();
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
  endtask

  // Brings the block to idle so that registers may be rewritten safely:
  // the last owed word is out, and any trailing event that produces no
  // word has had time to retire.
  task automatic settle();
    wait_results();
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      tsm_pkg::REG_ENABLED:     regs.enabled     = data[0];
      tsm_pkg::REG_AREA_ENABLE: regs.area_enable = data[0];
      tsm_pkg::REG_AREA_LEFT:   regs.area_left   = data;
      tsm_pkg::REG_AREA_TOP:    regs.area_top    = data;
      tsm_pkg::REG_AREA_RIGHT:  regs.area_right  = data;
      tsm_pkg::REG_AREA_BOTTOM: regs.area_bottom = data;
      tsm_pkg::REG_SCREEN_W:    regs.screen_w    = data[tsm_pkg::SCR_W-1:0];
      tsm_pkg::REG_SCREEN_H:    regs.screen_h    = data[tsm_pkg::SCR_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_area(input logic on, input logic [15:0] left, input logic [15:0] top,
                            input logic [15:0] right, input logic [15:0] bottom);
    write_reg(tsm_pkg::REG_AREA_ENABLE, {15'd0, on});
    write_reg(tsm_pkg::REG_AREA_LEFT, left);
    write_reg(tsm_pkg::REG_AREA_TOP, top);
    write_reg(tsm_pkg::REG_AREA_RIGHT, right);
    write_reg(tsm_pkg::REG_AREA_BOTTOM, bottom);
  endtask

  // Whole-pad scaling with the reset settings: zero, the pad edge, and
  // coordinates far past the pad that must saturate at the screen size.
  task automatic test_full_pad();
    send_event(tsm_pkg::MODE_X, 16'd0, 32'd0);
    send_event(tsm_pkg::MODE_X, 16'hFFFF, 32'd5);
    send_event(tsm_pkg::MODE_Y, 16'd4095, 32'd10);
    send_event(tsm_pkg::MODE_Y, 16'h5555, 32'd15);
    // The other axis stores nothing and produces only a sync.
    send_event(tsm_pkg::MODE_AXIS, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  // Taps, slow presses, repeats and a release with no press before it.
  task automatic test_touch_key();
    send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_PRESS, 32'd1000);
    send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_RELEASE, 32'd1199);
    // Exactly at the tap limit is no longer a tap.
    send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_PRESS, 32'd2000);
    send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_RELEASE, 32'd2200);
    send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_RELEASE, 32'd3000);
    // Repeats must neither arm nor clear the pending press.
    send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_PRESS, 32'd4000);
    send_event(tsm_pkg::MODE_KEY, 16'd2, 32'd4010);
    send_event(tsm_pkg::MODE_KEY, 16'hFFFF, 32'd4020);
    send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_RELEASE, 32'd4050);
    // The timestamp wraps between press and release.
    send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_PRESS, 32'hFFFF_FFF0);
    send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_RELEASE, 32'h0000_0050);
  endtask

  // Area mapping: points below, above and inside the area, empty areas,
  // and the widest possible area.
  task automatic test_area_map();
    settle();
    write_area(1'b1, 16'd100, 16'd200, 16'd3000, 16'd2500);
    write_reg(tsm_pkg::REG_SCREEN_W, 16'h3FFF);
    write_reg(tsm_pkg::REG_SCREEN_H, 16'd1);
    send_event(tsm_pkg::MODE_X, 16'd50, 32'd10);
    send_event(tsm_pkg::MODE_X, 16'd3500, 32'd11);
    send_event(tsm_pkg::MODE_Y, 16'd1350, 32'd12);
    settle();
    // Right equal to left and bottom below top both leave nothing to map.
    write_reg(tsm_pkg::REG_AREA_RIGHT, 16'd100);
    write_reg(tsm_pkg::REG_AREA_BOTTOM, 16'd150);
    send_event(tsm_pkg::MODE_X, 16'd1000, 32'd20);
    send_event(tsm_pkg::MODE_Y, 16'd1000, 32'd21);
    settle();
    write_area(1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    send_event(tsm_pkg::MODE_X, 16'hFFFF, 32'd30);
  endtask

  // A zero screen width maps everything to zero.
  task automatic test_screen_limits();
    settle();
    write_area(1'b0, 16'd0, 16'd0, 16'd4095, 16'd4095);
    write_reg(tsm_pkg::REG_SCREEN_W, 16'd0);
    send_event(tsm_pkg::MODE_X, 16'd4095, 32'd40);
    settle();
    write_reg(tsm_pkg::REG_SCREEN_W, 16'd1920);
    write_reg(tsm_pkg::REG_SCREEN_H, 16'd1080);
  endtask

  // While disabled nothing comes out and no state moves, so a press taken
  // while disabled must not turn a later release into a tap.
  task automatic test_disabled();
    settle();
    write_reg(tsm_pkg::REG_ENABLED, 16'd0);
    send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_PRESS, 32'd100);
    send_event(tsm_pkg::MODE_X, 16'd500, 32'd110);
    settle();
    write_reg(tsm_pkg::REG_ENABLED, 16'd1);
    send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_RELEASE, 32'd150);
  endtask

  function automatic logic [15:0] pick_coord();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 80) return 16'($urandom_range(0, 4200));
    if (roll < 92) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 2))
      0: return 16'd0;
      1: return 16'd4095;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_tap_delay();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 60) return $urandom_range(0, 199);
    if (roll < 70) return 32'd199;
    if (roll < 80) return 32'd200;
    return $urandom_range(201, 5000);
  endfunction

  task automatic randomize_settings(input logic on);
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] scr_w;
    logic [15:0] scr_h;
    left   = 16'($urandom_range(0, 2000));
    top    = 16'($urandom_range(0, 2000));
    right  = ($urandom_range(0, 99) < 15) ? 16'($urandom_range(0, left))
                                          : 16'($urandom_range(left + 1, left + 3000));
    bottom = ($urandom_range(0, 99) < 15) ? 16'($urandom_range(0, top))
                                          : 16'($urandom_range(top + 1, top + 3000));
    if ($urandom_range(0, 9) == 0) right = 16'hFFFF;
    case ($urandom_range(0, 9))
      0: scr_w = 16'h3FFF;
      1: scr_w = 16'd1;
      default: scr_w = 16'($urandom_range(100, 4000));
    endcase
    case ($urandom_range(0, 9))
      0: scr_h = 16'h3FFF;
      1: scr_h = 16'd1;
      default: scr_h = 16'($urandom_range(100, 4000));
    endcase
    write_area(on, left, top, right, bottom);
    write_reg(tsm_pkg::REG_SCREEN_W, scr_w);
    write_reg(tsm_pkg::REG_SCREEN_H, scr_h);
  endtask

  // Mostly realistic traffic: cursor moves and presses followed by a release
  // after a chosen delay, sometimes with drags in between. The rest is noise:
  // the other axis, key repeats, stray releases and arbitrary timestamps.
  task automatic random_traffic(input int count);
    int stop_at;
    int roll;
    int drags;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      roll   = int'($urandom_range(0, 99));
      now_ms = now_ms + $urandom_range(0, 30);
      if (roll < 35) begin
        send_event(tsm_pkg::MODE_X, pick_coord(), now_ms);
      end else if (roll < 62) begin
        send_event(tsm_pkg::MODE_Y, pick_coord(), now_ms);
      end else if (roll < 67) begin
        send_event(tsm_pkg::MODE_AXIS, 16'($urandom_range(0, 65535)), now_ms);
      end else if (roll < 90) begin
        send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_PRESS, now_ms);
        drags = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 3));
        repeat (drags) begin
          send_event(($urandom_range(0, 1) != 0) ? tsm_pkg::MODE_X : tsm_pkg::MODE_Y,
                     pick_coord(), now_ms);
        end
        now_ms = now_ms + pick_tap_delay();
        send_event(tsm_pkg::MODE_KEY, tsm_pkg::KEY_RELEASE, now_ms);
      end else begin
        send_event(tsm_pkg::MODE_KEY,
                   ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3))
                                               : 16'($urandom_range(0, 65535)),
                   ($urandom_range(0, 3) == 0) ? $urandom : now_ms);
      end
    end
  endtask

  // Several phases, each under fresh settings. The first runs with no idling
  // at all; halfway through each phase the sender waits for every result.
  task automatic test_random();
    int share;
    share = RANDOM_EVENTS / RANDOM_PHASES;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      idle_on = (phase != 0);
      randomize_settings(phase[0]);
      random_traffic(share / 2);
      wait_results();
      random_traffic(share - share / 2);
    end
    idle_on = 1'b1;
  endtask

  // The result side stalls at random, sometimes for a long stretch, and never
  // while idling is switched off.
  always @(posedge clk) begin
    if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (stall_run > 0) begin
      out_ready <= 1'b0;
      stall_run <= stall_run - 1;
    end else begin
      ready_roll = int'($urandom_range(0, 99));
      if (ready_roll < 70) begin
        out_ready <= 1'b1;
      end else if (ready_roll < 96) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b0;
        stall_run <= int'($urandom_range(8, 40));
      end
    end
  end

  // Each word taken from the block is compared with the oldest owed word.
  always @(posedge clk) begin
    tsm_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected result: kind %0d value %0d last %0d", $time,
                 out_word.kind, out_word.out_value, out_word.last);
        error_count++;
      end else begin
        want = owed_words.pop_front();
        if (out_word.kind !== want.kind || out_word.out_value !== want.out_value ||
            out_word.last !== want.last) begin
          $display("%0t: result mismatch: expected kind %0d value %0d last %0d,",
                   $time, want.kind, want.out_value, want.last);
          $display("%0t:   got kind %0d value %0d last %0d",
                   $time, out_word.kind, out_word.out_value, out_word.last);
          error_count++;
        end
      end
    end
  end

  // Guards against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("touch_to_screen_mapper verification failed");
      $finish;
    end
  end

  initial begin
    int waited;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    events_sent = 0;
    idle_on     = 1'b1;
    now_ms      = $urandom;

    // The shadow starts from the register defaults and a cleared touch state.
    regs.enabled     = 1'b1;
    regs.area_enable = 1'b0;
    regs.area_left   = '0;
    regs.area_top    = '0;
    regs.area_right  = 16'd4095;
    regs.area_bottom = 16'd4095;
    regs.screen_w    = 14'd1920;
    regs.screen_h    = 14'd1080;
    pad_x       = '0;
    pad_y       = '0;
    press_held  = 1'b0;
    press_stamp = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_pad();
    test_touch_key();
    test_area_map();
    test_screen_limits();
    test_disabled();
    test_random();

    // Let the last words drain, bounded, then allow any trailing work to retire.
    in_valid <= 1'b0;
    waited = 0;
    while (owed_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (QUIET_CYCLES) @(posedge clk);
    if (owed_words.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, owed_words.size());
    end

    if (error_count == 0 && owed_words.size() == 0) begin
      $display("touch_to_screen_mapper verification clean");
    end else begin
      $display("touch_to_screen_mapper verification failed");
    end
    $finish;
  end

endmodule
